/* hw/rtl/tsq_pkg.sv */
// Package for the TLB shootdown request queue: field widths, ring entry
// layout, result action codes, request codes and controller states.
// No dependencies.
package tsq_pkg;

  localparam int SEQ_W  = 64;
  localparam int ROOT_W = 52;
  localparam int ADDR_W = 64;
  localparam int ACT_W  = 3;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ~(ADDR_W'(PAGE_BYTES) - ADDR_W'(1));

  // request codes on in_req_type
  localparam logic REQ_ENQ   = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUEUED  = 3'd0,
    ACT_FORCED  = 3'd1,
    ACT_NONE    = 3'd2,
    ACT_PAGE    = 3'd3,
    ACT_ALL     = 3'd4,
    ACT_NOFLUSH = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // one stored request
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ROOT_W-1:0] root;
    logic [ADDR_W-1:0] addr;
    logic              all;
  } ring_entry_t;

  // controls from the sequencer into the scan accumulator
  typedef struct packed {
    logic clear;
    logic acc_en;
  } scan_ctl_t;

  // what the first walk over the ring found
  typedef struct packed {
    logic [SEQ_W-1:0] done_seq;
    logic             any_all;
    logic             has_match;
  } scan_acc_t;

endpackage

/* hw/rtl/tsq_scan.sv */
// Scan accumulator: folds ring entries read back during the first walk into
// the highest sequence, the whole-space and match flags and the last match.
// Depends on tsq_pkg.
module tsq_scan #(
  parameter int PTR_W = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tsq_pkg::scan_ctl_t        ctl,
  input  logic [tsq_pkg::SEQ_W-1:0]  init_seq,
  input  logic [tsq_pkg::ROOT_W-1:0] root,
  input  tsq_pkg::ring_entry_t      entry,
  input  logic [PTR_W-1:0]          entry_ptr,
  output tsq_pkg::scan_acc_t        acc,
  output logic [PTR_W-1:0]          last_ptr,
  output logic                      hit
);

  tsq_pkg::scan_acc_t acc_r;
  logic [PTR_W-1:0]   last_ptr_r;

  // entry belongs to the current address space
  assign hit = (entry.root == root);

  // accumulate over the returned entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r.done_seq  <= '0;
      acc_r.any_all   <= 1'b0;
      acc_r.has_match <= 1'b0;
    end else if (ctl.clear) begin
      acc_r.done_seq  <= init_seq;
      acc_r.any_all   <= 1'b0;
      acc_r.has_match <= 1'b0;
    end else if (ctl.acc_en) begin
      if (entry.seq > acc_r.done_seq) begin
        acc_r.done_seq <= entry.seq;
      end
      if (hit) begin
        acc_r.has_match <= 1'b1;
        if (entry.all) begin
          acc_r.any_all <= 1'b1;
        end
      end
    end
  end

  // ring slot of the latest matching entry, marks the final page flush
  always_ff @(posedge clk) begin
    if (ctl.acc_en && hit) begin
      last_ptr_r <= entry_ptr;
    end
  end

  assign acc      = acc_r;
  assign last_ptr = last_ptr_r;

endmodule

/* hw/rtl/tlb_shootdown_request_queue.sv */
// TLB shootdown request queue, top level: ring memory, pointers, sequence
// counters and the drain sequencer. Depends on tsq_pkg and tsq_scan.
//
// Usage:
//  An item is taken when start is high and busy is low. in_req_type selects
//  an enqueue (request stored in the ring, or the force mark set when the
//  ring is full) or a drain of the ring for the address space in_space_root.
//  Results come out on the out_ ports for one cycle each, marked by out_valid;
//  out_last flags the final result of an item. The receiver cannot stall.
//  Timing and rate:
//  - enqueue: result in the cycle after acceptance, busy stays low, so one
//    enqueue per cycle is taken.
//  - drain with an empty ring and no force mark: result in the next cycle.
//  - drain of N queued entries: the ring is walked once to find the highest
//    sequence and the flags, and, when page flushes are due, a second time
//    emitting one result per matching entry. The ring memory has a single
//    read port; busy stays high until the walks are done.
//  Reset clears pointers, sequence counters and the force mark; the ring
//  contents are not cleared, since only written slots are ever read.
module tlb_shootdown_request_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [tsq_pkg::ROOT_W-1:0]  in_space_root,
  input  logic [tsq_pkg::ADDR_W-1:0]  in_virt_addr,
  input  logic                        in_whole_space,
  output logic                        out_valid,
  output logic [tsq_pkg::ACT_W-1:0]   out_action,
  output logic [tsq_pkg::SEQ_W-1:0]   out_sequence_res,
  output logic [tsq_pkg::ADDR_W-1:0]  out_flush_addr,
  output logic                        out_last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  // state registers
  tsq_pkg::state_t             state_r, state_nxt;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [PTR_W-1:0]            tail_r, tail_nxt;
  logic                        force_flag_r, force_flag_nxt;
  logic [tsq_pkg::SEQ_W-1:0]   force_seq_r, force_seq_nxt;
  logic [tsq_pkg::SEQ_W-1:0]   next_seq_r, next_seq_nxt;
  logic [tsq_pkg::SEQ_W-1:0]   completed_r, completed_nxt;

  // drain context
  logic [tsq_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic                        forced_r, forced_nxt;
  logic [PTR_W-1:0]            start_ptr_r, start_ptr_nxt;
  logic [PTR_W-1:0]            cnt_r, cnt_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]            left_r, left_nxt;
  logic                        rd_valid_r;
  logic [PTR_W-1:0]            rd_slot_r;
  tsq_pkg::ring_entry_t        rd_data_r;

  // result registers
  logic                        out_valid_r, out_valid_nxt;
  tsq_pkg::action_t            out_action_r, out_action_nxt;
  logic [tsq_pkg::SEQ_W-1:0]   out_seq_r, out_seq_nxt;
  logic [tsq_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic                        out_last_r, out_last_nxt;

  // ring memory
  tsq_pkg::ring_entry_t        ring_mem [QUEUE_DEPTH];
  tsq_pkg::ring_entry_t        wr_entry;
  logic                        wr_en;
  logic                        rd_issue;

  // control and scan
  logic                        accept, is_enq, ring_full, drain_empty;
  logic [PTR_W-1:0]            tail_inc;
  logic [PTR_W:0]              occ_ext;
  logic [PTR_W-1:0]            occ;
  logic [tsq_pkg::SEQ_W-1:0]   seq_new;
  logic                        walk_done, go_flush;
  tsq_pkg::scan_ctl_t          scan_ctl;
  tsq_pkg::scan_acc_t          scan_acc;
  logic [PTR_W-1:0]            last_ptr;
  logic                        hit;

  // item decode and ring occupancy
  assign busy        = (state_r != tsq_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign is_enq      = (in_req_type == tsq_pkg::REQ_ENQ);
  assign tail_inc    = ptr_inc(tail_r);
  assign ring_full   = (tail_inc == head_r);
  assign seq_new     = next_seq_r + tsq_pkg::SEQ_W'(1);
  assign occ_ext     = (tail_r >= head_r) ? ({1'b0, tail_r} - {1'b0, head_r})
                                          : ({1'b0, tail_r} + DEPTH_EXT - {1'b0, head_r});
  assign occ         = occ_ext[PTR_W-1:0];
  assign drain_empty = (occ == '0) && !force_flag_r;
  assign walk_done   = (left_r == '0) && !rd_valid_r;
  assign go_flush    = !forced_r && !scan_acc.any_all && scan_acc.has_match;

  assign wr_entry.seq  = seq_new;
  assign wr_entry.root = in_space_root;
  assign wr_entry.addr = in_virt_addr;
  assign wr_entry.all  = in_whole_space;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsq_pkg::ST_IDLE: begin
        if (accept && !is_enq && !drain_empty) begin
          state_nxt = tsq_pkg::ST_SCAN;
        end
      end
      tsq_pkg::ST_SCAN: begin
        if (walk_done) begin
          state_nxt = go_flush ? tsq_pkg::ST_FLUSH : tsq_pkg::ST_IDLE;
        end
      end
      tsq_pkg::ST_FLUSH: begin
        if (walk_done) begin
          state_nxt = tsq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsq_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: memory port and scan controls
  always_comb begin
    wr_en           = 1'b0;
    rd_issue        = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.acc_en = 1'b0;
    case (state_r)
      tsq_pkg::ST_IDLE: begin
        wr_en          = accept && is_enq && !ring_full;
        scan_ctl.clear = accept && !is_enq;
      end
      tsq_pkg::ST_SCAN: begin
        rd_issue        = (left_r != '0);
        scan_ctl.acc_en = rd_valid_r;
      end
      tsq_pkg::ST_FLUSH: begin
        rd_issue = (left_r != '0);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    force_flag_nxt = force_flag_r;
    force_seq_nxt  = force_seq_r;
    next_seq_nxt   = next_seq_r;
    completed_nxt  = completed_r;
    root_nxt       = root_r;
    forced_nxt     = forced_r;
    start_ptr_nxt  = start_ptr_r;
    cnt_nxt        = cnt_r;
    rd_ptr_nxt     = rd_issue ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    left_nxt       = rd_issue ? left_r - 1'b1 : left_r;
    out_valid_nxt  = 1'b0;
    out_action_nxt = out_action_r;
    out_seq_nxt    = out_seq_r;
    out_addr_nxt   = out_addr_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      tsq_pkg::ST_IDLE: begin
        if (accept && is_enq) begin
          next_seq_nxt   = seq_new;
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = seq_new;
          out_addr_nxt   = '0;
          out_last_nxt   = 1'b1;
          if (ring_full) begin
            force_flag_nxt = 1'b1;
            if (seq_new > force_seq_r) begin
              force_seq_nxt = seq_new;
            end
            out_action_nxt = tsq_pkg::ACT_FORCED;
          end else begin
            tail_nxt       = tail_inc;
            out_action_nxt = tsq_pkg::ACT_QUEUED;
          end
        end else if (accept) begin
          head_nxt       = tail_r;
          force_flag_nxt = 1'b0;
          force_seq_nxt  = '0;
          root_nxt       = in_space_root;
          forced_nxt     = force_flag_r;
          start_ptr_nxt  = head_r;
          cnt_nxt        = occ;
          rd_ptr_nxt     = head_r;
          left_nxt       = occ;
          if (drain_empty) begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = tsq_pkg::ACT_NONE;
            out_seq_nxt    = completed_r;
            out_addr_nxt   = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      tsq_pkg::ST_SCAN: begin
        if (walk_done) begin
          completed_nxt = scan_acc.done_seq;
          out_seq_nxt   = scan_acc.done_seq;
          out_addr_nxt  = '0;
          out_last_nxt  = 1'b1;
          if (go_flush) begin
            // second walk from the same start
            rd_ptr_nxt = start_ptr_r;
            left_nxt   = cnt_r;
          end else begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = (forced_r || scan_acc.any_all) ? tsq_pkg::ACT_ALL
                                                            : tsq_pkg::ACT_NOFLUSH;
          end
        end
      end
      tsq_pkg::ST_FLUSH: begin
        if (rd_valid_r && hit) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = tsq_pkg::ACT_PAGE;
          out_seq_nxt    = scan_acc.done_seq;
          out_addr_nxt   = rd_data_r.addr & tsq_pkg::PAGE_MASK;
          out_last_nxt   = (rd_slot_r == last_ptr);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsq_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      force_flag_r <= 1'b0;
      force_seq_r  <= '0;
      next_seq_r   <= '0;
      completed_r  <= '0;
      forced_r     <= 1'b0;
      left_r       <= '0;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      force_flag_r <= force_flag_nxt;
      force_seq_r  <= force_seq_nxt;
      next_seq_r   <= next_seq_nxt;
      completed_r  <= completed_nxt;
      forced_r     <= forced_nxt;
      left_r       <= left_nxt;
      rd_valid_r   <= rd_issue;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    root_r       <= root_nxt;
    start_ptr_r  <= start_ptr_nxt;
    cnt_r        <= cnt_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    rd_slot_r    <= rd_ptr_r;
    out_action_r <= out_action_nxt;
    out_seq_r    <= out_seq_nxt;
    out_addr_r   <= out_addr_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ring write: only in idle, reads only while draining, so no overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tail_r] <= wr_entry;
    end
  end

  // ring read, registered
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= ring_mem[rd_ptr_r];
    end
  end

  tsq_scan #(
    .PTR_W (PTR_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .init_seq  (force_seq_r),
    .root      (root_r),
    .entry     (rd_data_r),
    .entry_ptr (rd_slot_r),
    .acc       (scan_acc),
    .last_ptr  (last_ptr),
    .hit       (hit)
  );

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_sequence_res = out_seq_r;
  assign out_flush_addr   = out_addr_r;
  assign out_last         = out_last_r;

  // an enqueue always answers on the next cycle with a single result
  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_enq |=> out_valid && out_last &&
      (out_action == tsq_pkg::ACT_QUEUED || out_action == tsq_pkg::ACT_FORCED))
    else $error("enqueue result missing or malformed");

  // a drain with nothing pending does not occupy the block
  a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_enq && drain_empty |=> !busy && out_valid &&
      out_action == tsq_pkg::ACT_NONE)
    else $error("empty drain did not answer at once");

  // after any drain the ring is empty
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_enq |=> head_r == tail_r && !force_flag_r)
    else $error("drain left entries or the force mark behind");

  // page flushes only come out of the second walk
  a_page_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == tsq_pkg::ACT_PAGE |-> $past(state_r) == tsq_pkg::ST_FLUSH)
    else $error("page flush outside the flush walk");

endmodule

/* bench/tsq_checker.sv */
// Checker for the TLB shootdown request queue: watches the item and result
// ports, predicts every result and compares them in order.
// Depends on tsq_pkg.
module tsq_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_req_type,
  input  logic [tsq_pkg::ROOT_W-1:0] in_space_root,
  input  logic [tsq_pkg::ADDR_W-1:0] in_virt_addr,
  input  logic                       in_whole_space,
  input  logic                       out_valid,
  input  logic [tsq_pkg::ACT_W-1:0]  out_action,
  input  logic [tsq_pkg::SEQ_W-1:0]  out_sequence_res,
  input  logic [tsq_pkg::ADDR_W-1:0] out_flush_addr,
  input  logic                       out_last,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    tsq_pkg::action_t           act;
    logic [tsq_pkg::SEQ_W-1:0]  seq;
    logic [tsq_pkg::ADDR_W-1:0] addr;
    logic                       last;
  } flush_result_t;

  localparam logic [tsq_pkg::ADDR_W-1:0] PAGE_ALIGN =
    ~(tsq_pkg::ADDR_W'(tsq_pkg::PAGE_BYTES) - tsq_pkg::ADDR_W'(1));

  flush_result_t     pending_results[$];

  // shadow copy of the queue state
  tsq_pkg::ring_entry_t       shadow_ring [QUEUE_DEPTH];
  int unsigned                shadow_head;
  int unsigned                shadow_tail;
  logic                       shadow_force;
  logic [tsq_pkg::SEQ_W-1:0]  shadow_force_seq;
  logic [tsq_pkg::SEQ_W-1:0]  shadow_next_seq;
  logic [tsq_pkg::SEQ_W-1:0]  shadow_completed;

  task automatic push_result(input tsq_pkg::action_t act,
                             input logic [tsq_pkg::SEQ_W-1:0] seq,
                             input logic [tsq_pkg::ADDR_W-1:0] addr, input logic last);
    flush_result_t r;
    r = '{act: act, seq: seq, addr: addr, last: last};
    pending_results.push_back(r);
  endtask

  // Works out the results of one accepted item and updates the shadow state
  task automatic predict_shootdown(input logic req, input logic [tsq_pkg::ROOT_W-1:0] root,
                                   input logic [tsq_pkg::ADDR_W-1:0] va, input logic whole);
    int unsigned               nxt_tail;
    int unsigned               walk_base;
    int unsigned               cnt;
    int unsigned               idx;
    int                        n;
    logic [tsq_pkg::SEQ_W-1:0] seq;
    logic [tsq_pkg::SEQ_W-1:0] done;
    logic                      forced;
    logic                      any_all;
    if (req == tsq_pkg::REQ_ENQ) begin
      seq = shadow_next_seq + tsq_pkg::SEQ_W'(1);
      nxt_tail = (shadow_tail + 1) % QUEUE_DEPTH;
      shadow_next_seq = seq;
      if (nxt_tail == shadow_head) begin
        // ring full: remember the highest forced sequence instead
        shadow_force = 1'b1;
        if (seq > shadow_force_seq) shadow_force_seq = seq;
        push_result(tsq_pkg::ACT_FORCED, seq, '0, 1'b1);
      end else begin
        shadow_ring[shadow_tail] = '{seq: seq, root: root, addr: va, all: whole};
        shadow_tail = nxt_tail;
        push_result(tsq_pkg::ACT_QUEUED, seq, '0, 1'b1);
      end
      return;
    end

    // drain: find the highest queued sequence, then empty the ring
    walk_base = shadow_head;
    cnt = (shadow_tail + QUEUE_DEPTH - shadow_head) % QUEUE_DEPTH;
    done = '0;
    forced = shadow_force;
    any_all = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      idx = (walk_base + i) % QUEUE_DEPTH;
      if (shadow_ring[idx].seq > done) done = shadow_ring[idx].seq;
    end
    shadow_head = shadow_tail;
    if (shadow_force_seq > done) done = shadow_force_seq;
    shadow_force = 1'b0;
    shadow_force_seq = '0;

    if (cnt == 0 && !forced) begin
      push_result(tsq_pkg::ACT_NONE, shadow_completed, '0, 1'b1);
      return;
    end
    shadow_completed = done;

    if (!forced) begin
      for (int i = 0; i < cnt; i++) begin
        idx = (walk_base + i) % QUEUE_DEPTH;
        if (shadow_ring[idx].root == root && shadow_ring[idx].all) any_all = 1'b1;
      end
    end
    if (forced || any_all) begin
      push_result(tsq_pkg::ACT_ALL, done, '0, 1'b1);
      return;
    end

    // one page flush per request of the current space
    n = 0;
    for (int i = 0; i < cnt; i++) begin
      idx = (walk_base + i) % QUEUE_DEPTH;
      if (shadow_ring[idx].root == root) begin
        push_result(tsq_pkg::ACT_PAGE, done, shadow_ring[idx].addr & PAGE_ALIGN, 1'b0);
        n++;
      end
    end
    if (n == 0) push_result(tsq_pkg::ACT_NOFLUSH, done, '0, 1'b1);
    else pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  // compare results first: none can belong to an item taken at this edge
  always @(posedge clk) begin : monitor
    flush_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      shadow_head = 0;
      shadow_tail = 0;
      shadow_force = 1'b0;
      shadow_force_seq = '0;
      shadow_next_seq = '0;
      shadow_completed = '0;
      mismatches = 0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: act=%0d seq=%0h addr=%0h last=%0b",
                     out_action, out_sequence_res, out_flush_addr, out_last);
        end else begin
          want = pending_results.pop_front();
          if (out_action !== want.act || out_sequence_res !== want.seq ||
              out_flush_addr !== want.addr || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected act=%0d seq=%0h addr=%0h last=%0b, %s",
                       want.act, want.seq, want.addr, want.last,
                       $sformatf("got act=%0d seq=%0h addr=%0h last=%0b",
                                 out_action, out_sequence_res, out_flush_addr,
                                 out_last));
          end
        end
      end
      if (start && !busy)
        predict_shootdown(in_req_type, in_space_root, in_virt_addr, in_whole_space);
    end
    outstanding <= pending_results.size();
  end

endmodule

/* bench/tb_tlb_shootdown_request_queue.sv */
// Testbench top for the TLB shootdown request queue: clock, reset, item
// stimulus, watchdog and verdict. Depends on tsq_pkg, tsq_checker and the RTL.
module tb_tlb_shootdown_request_queue;

  localparam int DEPTH      = 64;
  localparam int ITEM_COUNT = 460;
  localparam int IDLE_LIMIT = 2000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_req_type;
  logic [tsq_pkg::ROOT_W-1:0] in_space_root;
  logic [tsq_pkg::ADDR_W-1:0] in_virt_addr;
  logic                       in_whole_space;
  logic                       out_valid;
  logic [tsq_pkg::ACT_W-1:0]  out_action;
  logic [tsq_pkg::SEQ_W-1:0]  out_sequence_res;
  logic [tsq_pkg::ADDR_W-1:0] out_flush_addr;
  logic                       out_last;
  int                         mismatches;
  int                         outstanding;
  int                         idle_cycles;
  int                         items_sent;
  logic                       gaps_on;
  logic [tsq_pkg::ROOT_W-1:0] space_pool [4];

  tlb_shootdown_request_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_space_root(in_space_root),
    .in_virt_addr(in_virt_addr), .in_whole_space(in_whole_space),
    .out_valid(out_valid), .out_action(out_action),
    .out_sequence_res(out_sequence_res), .out_flush_addr(out_flush_addr),
    .out_last(out_last)
  );

  tsq_checker #(.QUEUE_DEPTH(DEPTH)) chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_space_root(in_space_root),
    .in_virt_addr(in_virt_addr), .in_whole_space(in_whole_space),
    .out_valid(out_valid), .out_action(out_action),
    .out_sequence_res(out_sequence_res), .out_flush_addr(out_flush_addr),
    .out_last(out_last), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles with no item taken and no result given
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_tlb_shootdown_request_queue: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [tsq_pkg::ROOT_W-1:0] pick_space();
    return space_pool[$urandom_range(0, 3)];
  endfunction

  // present one item at the falling edge and hold it until taken
  task automatic send_item(input logic req, input logic [tsq_pkg::ROOT_W-1:0] root,
                           input logic [tsq_pkg::ADDR_W-1:0] va, input logic whole);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      in_virt_addr = rand64();
    end
    @(negedge clk);
    start = 1'b1;
    in_req_type = req;
    in_space_root = root;
    in_virt_addr = va;
    in_whole_space = whole;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic enqueue(input logic [tsq_pkg::ROOT_W-1:0] root,
                         input logic [tsq_pkg::ADDR_W-1:0] va, input logic whole);
    send_item(tsq_pkg::REQ_ENQ, root, va, whole);
  endtask

  task automatic drain(input logic [tsq_pkg::ROOT_W-1:0] root);
    send_item(tsq_pkg::REQ_DRAIN, root, rand64(), 1'($urandom_range(0, 1)));
  endtask

  // hold off until every expected result has come
  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int                         sel;
    int                         len;
    logic                       same_space;
    logic [tsq_pkg::ROOT_W-1:0] target;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = tsq_pkg::REQ_ENQ;
    in_space_root = '0;
    in_virt_addr = '0;
    in_whole_space = 1'b0;
    items_sent = 0;
    gaps_on = 1'b0;
    space_pool[0] = '0;
    space_pool[1] = '1;
    space_pool[2] = tsq_pkg::ROOT_W'(rand64());
    space_pool[3] = tsq_pkg::ROOT_W'(rand64());
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: nothing pending, page flushes at the address extremes
    drain('0);
    enqueue('0, '0, 1'b0);
    enqueue('1, '1, 1'b0);
    enqueue('0, 64'h0000_0000_0000_0fff, 1'b0);
    enqueue('0, '1, 1'b0);
    drain('0);
    // whole-space request for the current space forces one full flush
    enqueue('1, 64'h8000_0000_0000_1234, 1'b1);
    enqueue('0, 64'h0000_0000_0000_5000, 1'b0);
    drain('1);
    // requests only for other spaces: drained without a flush
    enqueue(52'h5, 64'h1000, 1'b0);
    enqueue(52'h6, 64'h2000, 1'b1);
    drain(52'h7);
    drain(52'h7);
    // back to back enqueues, then a drain right after
    gaps_on = 1'b0;
    enqueue(space_pool[2], rand64(), 1'b0);
    enqueue(space_pool[2], rand64(), 1'b0);
    enqueue(space_pool[3], rand64(), 1'b1);
    drain(space_pool[2]);
    wait_quiet();

    // overflow the ring once so the force mark is set
    gaps_on = 1'b1;
    target = pick_space();
    repeat (DEPTH + 2) enqueue(target, rand64(), 1'b0);
    drain(target);

    // random bursts of enqueues closed by a drain, with some noise
    while (items_sent < ITEM_COUNT) begin
      gaps_on = ($urandom_range(0, 9) >= 3);
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0)
        space_pool[$urandom_range(2, 3)] = tsq_pkg::ROOT_W'(rand64());
      if (sel < 6) begin
        // long burst: DEPTH - 1 requests of one space for a maximal flush run, or near or over the top
        len = $urandom_range(0, 1) ? DEPTH - 1 : $urandom_range(DEPTH - 4, DEPTH + 6);
        same_space = (len == DEPTH - 1);
        target = pick_space();
        repeat (len)
          enqueue(same_space ? target : pick_space(), rand64(),
                  same_space ? 1'b0 : ($urandom_range(0, 5) == 0));
        drain(target);
      end else if (sel < 86) begin
        len = $urandom_range(0, 12);
        repeat (len) enqueue(pick_space(), rand64(), $urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) wait_quiet();
        drain(pick_space());
      end else begin
        send_item(1'($urandom_range(0, 1)), tsq_pkg::ROOT_W'(rand64()), rand64(),
                  1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 7) == 0) wait_quiet();
    end

    wait_quiet();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_tlb_shootdown_request_queue: PASS");
    end else begin
      $display("tb_tlb_shootdown_request_queue: FAIL");
    end
    $finish;
  end

endmodule

/* tlb_shootdown_request_queue.f */
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_scan.sv
hw/rtl/tlb_shootdown_request_queue.sv
bench/tsq_checker.sv
bench/tb_tlb_shootdown_request_queue.sv
